[design/mkc_pkg.sv]
package mkc_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int NUM_CLASSES = 9;
  localparam int NUM_REPORT  = 11;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [4:0]            weight_t;
  typedef logic [3:0]            report_idx_t;

  localparam report_idx_t IDX_INSTR  = 4'd9;
  localparam report_idx_t IDX_CYCLES = 4'd10;

  localparam logic [31:0] KW_CODE [NUM_CLASSES] = '{
    32'h006D6F76,
    32'h00616464,
    32'h006D756C,
    32'h00646976,
    32'h006C6561,
    32'h70757368,
    32'h00706F70,
    32'h00726574,
    32'h00737562
  };

  localparam logic [NUM_CLASSES-1:0] KW_FOUR = 9'b000100000;

  localparam weight_t KW_WEIGHT [NUM_CLASSES] = '{
    5'd1, 5'd1, 5'd3, 5'd24, 5'd3, 5'd1, 5'd1, 5'd1, 5'd1
  };

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_stream;
  } text_item_t;

  typedef struct packed {
    logic [3:0]  report_index;
    logic [31:0] report_value;
    logic        report_last;
  } report_item_t;

  typedef struct packed {
    logic        hit;
    report_idx_t cls;
  } close_t;

  typedef enum logic {
    REP_IDLE,
    REP_RUN
  } rep_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic count_t sat_add(input count_t a, input weight_t b);
    logic [COUNT_BITS:0] sum;
    sum = {1'b0, a} + (COUNT_BITS + 1)'(b);
    if (sum[COUNT_BITS]) begin
      return '1;
    end
    return sum[COUNT_BITS-1:0];
  endfunction

  function automatic logic [31:0] report_word(input count_t v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'h0000_0000_FFFF_FFFF) begin
      return 32'hFFFF_FFFF;
    end
    return w[31:0];
  endfunction

endpackage

[design/mkc_matcher.sv]
module mkc_matcher (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  mkc_pkg::text_item_t item,
  output mkc_pkg::close_t     close
);
  import mkc_pkg::*;

  logic [23:0]            recent;
  logic                   token_open;
  logic [NUM_CLASSES-1:0] seen;

  logic [23:0]            recent_base;
  logic [NUM_CLASSES-1:0] seen_base;
  logic [31:0]            win;
  logic [NUM_CLASSES-1:0] match;
  logic                   ends;

  assign recent_base = token_open ? recent : 24'd0;
  assign seen_base   = token_open ? seen : '0;
  assign win         = {recent_base, item.symbol};
  assign ends        = item.end_of_stream || is_space(item.symbol);

  always_comb begin
    for (int k = 0; k < NUM_CLASSES; k++) begin
      match[k] = KW_FOUR[k] ? (win == KW_CODE[k]) : (win[23:0] == KW_CODE[k][23:0]);
    end
  end

  always_comb begin
    close.hit = item_valid && ends && token_open && (|seen);
    close.cls = '0;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (seen[k]) begin
        close.cls = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent     <= '0;
      token_open <= 1'b0;
      seen       <= '0;
    end else if (item_valid) begin
      if (ends) begin
        recent     <= '0;
        token_open <= 1'b0;
        seen       <= '0;
      end else begin
        recent     <= win[23:0];
        token_open <= 1'b1;
        seen       <= seen_base | match;
      end
    end
  end

endmodule

[design/mkc_counters.sv]
module mkc_counters (
  input  logic                  clk,
  input  logic                  rst,
  input  mkc_pkg::close_t       close,
  input  logic                  start,
  input  logic                  report_stall,
  output logic                  report_valid,
  output mkc_pkg::report_item_t report,
  output logic                  busy
);
  import mkc_pkg::*;

  count_t      counts [NUM_REPORT];
  rep_state_t  state;
  rep_state_t  state_next;
  report_idx_t rep_idx;
  logic        load;
  logic        last;

  always_comb begin
    state_next = state;
    unique case (state)
      REP_IDLE: begin
        if (start) begin
          state_next = REP_RUN;
        end
      end
      REP_RUN: begin
        if (load && last) begin
          state_next = REP_IDLE;
        end
      end
      default: state_next = REP_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    busy = 1'b0;
    unique case (state)
      REP_IDLE: begin
        load = 1'b0;
        busy = 1'b0;
      end
      REP_RUN: begin
        load = !report_valid || !report_stall;
        busy = 1'b1;
      end
      default: begin
        load = 1'b0;
        busy = 1'b0;
      end
    endcase
  end

  assign last = (rep_idx == IDX_CYCLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= REP_IDLE;
      rep_idx <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        rep_idx <= '0;
      end else if (load) begin
        rep_idx <= rep_idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REPORT; k++) begin
        counts[k] <= '0;
      end
    end else if (load && last) begin
      for (int k = 0; k < NUM_REPORT; k++) begin
        counts[k] <= '0;
      end
    end else if (close.hit) begin
      counts[close.cls]  <= sat_add(counts[close.cls], 5'd1);
      counts[IDX_INSTR]  <= sat_add(counts[IDX_INSTR], 5'd1);
      counts[IDX_CYCLES] <= sat_add(counts[IDX_CYCLES], KW_WEIGHT[close.cls]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_valid <= 1'b0;
    end else if (load) begin
      report_valid <= 1'b1;
    end else if (!report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      report.report_index <= rep_idx;
      report.report_value <= report_word(counts[rep_idx]);
      report.report_last  <= last;
    end
  end

  // The cycle total never falls below the instruction total, since every weight is at least one.
  a_cycles_ge_instr: assert property (@(posedge clk) disable iff (rst)
    counts[IDX_CYCLES] >= counts[IDX_INSTR])
    else $error("cycle total below instruction total");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == REP_RUN) && (rep_idx == 4'd0))
    else $error("report run did not begin at index zero");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == REP_RUN) |-> (rep_idx <= IDX_CYCLES))
    else $error("report index out of range");

  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (load && last) |=> (counts[IDX_INSTR] == '0) && (state == REP_IDLE))
    else $error("totals not cleared after report run");

  a_no_close_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == REP_RUN) |-> !close.hit)
    else $error("token closed during report run");

endmodule

[design/mnemonic_keyword_counter.sv]
// Input: a byte is registered at acceptance and updates token and counters in the next cycle.
// Throughput: one byte per cycle unless stalled, set by the window compare and saturating adds.
// End of stream: via in_q and the state register, the first of eleven report items is registered;
// then one item per cycle unless report_stall is high; input stalls until the last item is loaded.
// Reset: synchronous, active high; clears token state, all totals and both valid flags.
module mnemonic_keyword_counter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  mkc_pkg::text_item_t   text,
  output logic                  report_valid,
  input  logic                  report_stall,
  output mkc_pkg::report_item_t report
);
  import mkc_pkg::*;

  text_item_t in_q;
  logic       in_q_valid;
  logic       busy;
  logic       start;
  close_t     close;

  assign start      = in_q_valid && in_q.end_of_stream;
  assign text_stall = busy || start;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= text_valid && !text_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      in_q <= text;
    end
  end

  mkc_matcher u_matcher (
    .clk        (clk),
    .rst        (rst),
    .item_valid (in_q_valid),
    .item       (in_q),
    .close      (close)
  );

  mkc_counters u_counters (
    .clk          (clk),
    .rst          (rst),
    .close        (close),
    .start        (start),
    .report_stall (report_stall),
    .report_valid (report_valid),
    .report       (report),
    .busy         (busy)
  );

endmodule
